// ===== design/lsdr_pkg.sv =====
// Shared constants, types and command/status structs for the base-10 radix sorter.
`timescale 1ns / 1ps

package lsdr_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int VALUE_W   = 10;
  localparam int DIG_W     = 4;
  localparam int BCD_W     = 3 * DIG_W;
  localparam int NDIG_W    = 2;
  localparam int RADIX     = 10;
  localparam int VALUE_MAX = 999;

  // floor(x / 10) == (x * 205) >> 11 for every x below 1029
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;

  // what the second stage does with the registered memory read
  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_CNT  = 3'd1,
    RD_SCT  = 3'd2,
    RD_CPY  = 3'd3,
    RD_EMIT = 3'd4
  } rd_mode_t;

  typedef struct packed {
    logic              cap_in;
    logic              conv;
    logic              store;
    logic              clr_cnt;
    logic              pfx;
    logic [DIG_W-1:0]  pfx_k;
    rd_mode_t          rd_mode;
    logic [ADDR_W-1:0] idx;
    logic [NDIG_W-1:0] digit;
    logic              em_load;
    logic              em_last;
    logic              end_set;
  } lsdr_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             last;
    logic             out_free;
  } lsdr_status_t;

endpackage

// ===== design/lsdr_dp.sv =====
// Datapath: input capture, BCD conversion, value/scratch stores, bucket counters, output reg.
`timescale 1ns / 1ps

module lsdr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsdr_pkg::lsdr_cmd_t            cmd,
  output lsdr_pkg::lsdr_status_t         status,
  input  logic [lsdr_pkg::VALUE_W-1:0]   in_value,
  input  logic                           in_last,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [lsdr_pkg::VALUE_W-1:0]   out_sorted_value,
  output logic                           out_last_out,
  output logic                           out_overflow
);
  import lsdr_pkg::*;

  localparam int QPROD_W = VALUE_W + 8;

  // stores hold values as three BCD digits
  logic [BCD_W-1:0]   mem_a [MAX_ITEMS];
  logic [BCD_W-1:0]   mem_b [MAX_ITEMS];
  logic [BCD_W-1:0]   a_rd_r;
  logic [BCD_W-1:0]   b_rd_r;
  rd_mode_t           rd_mode_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [NDIG_W-1:0]  digit_r;

  logic [CNT_W-1:0]   cnt_r   [RADIX];
  logic [CNT_W-1:0]   cnt_nxt [RADIX];
  logic [CNT_W-1:0]   acc_r;
  logic [CNT_W-1:0]   pfx_sum;

  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               dropped_r, dropped_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic [VALUE_W-1:0] v_r;
  logic               last_r;
  logic [6:0]         q_r;
  logic [DIG_W-1:0]   d0_r;

  logic [QPROD_W-1:0] q_prod;
  logic [6:0]         q_val;
  logic [DIG_W-1:0]   d0_val;
  logic [QPROD_W-1:0] q1_prod;
  logic [DIG_W-1:0]   d1_val;
  logic [DIG_W-1:0]   d2_val;

  logic [DIG_W-1:0]   dig;
  logic               dig_ok;
  logic [ADDR_W-1:0]  sct_pos;
  logic               out_xfer;
  logic               store_ok;

  function automatic logic [VALUE_W-1:0] bcd2bin(input logic [BCD_W-1:0] b);
    logic [VALUE_W-1:0] h, t, u;
    h = VALUE_W'(b[3*DIG_W-1:2*DIG_W]);
    t = VALUE_W'(b[2*DIG_W-1:DIG_W]);
    u = VALUE_W'(b[DIG_W-1:0]);
    return (h * VALUE_W'(100)) + (t * VALUE_W'(RADIX)) + u;
  endfunction

  // binary to BCD, one divide-by-ten per cycle
  assign q_prod  = QPROD_W'(v_r) * QPROD_W'(DIV10_MUL);
  assign q_val   = 7'(q_prod >> DIV10_SHIFT);
  assign d0_val  = DIG_W'(v_r - (VALUE_W'(q_val) * VALUE_W'(RADIX)));
  assign q1_prod = QPROD_W'(q_r) * QPROD_W'(DIV10_MUL);
  assign d2_val  = DIG_W'(q1_prod >> DIV10_SHIFT);
  assign d1_val  = DIG_W'(q_r - (7'(d2_val) * 7'(RADIX)));

  assign store_ok = (fill_r < CNT_W'(MAX_ITEMS));

  always_comb begin
    case (digit_r)
      2'd0:    dig = a_rd_r[DIG_W-1:0];
      2'd1:    dig = a_rd_r[2*DIG_W-1:DIG_W];
      default: dig = a_rd_r[3*DIG_W-1:2*DIG_W];
    endcase
  end

  assign dig_ok  = (dig < DIG_W'(RADIX));
  assign sct_pos = dig_ok ? ADDR_W'(cnt_r[dig] - CNT_W'(1)) : '0;
  assign pfx_sum = ((cmd.pfx_k == '0) ? '0 : acc_r) + cnt_r[cmd.pfx_k];

  always_comb begin
    for (int j = 0; j < RADIX; j++) begin
      cnt_nxt[j] = cnt_r[j];
    end
    if (cmd.clr_cnt || cmd.end_set) begin
      for (int j = 0; j < RADIX; j++) begin
        cnt_nxt[j] = '0;
      end
    end else if (cmd.pfx) begin
      cnt_nxt[cmd.pfx_k] = pfx_sum;
    end else if (dig_ok) begin
      case (rd_mode_r)
        RD_CNT:  cnt_nxt[dig] = cnt_r[dig] + CNT_W'(1);
        RD_SCT:  cnt_nxt[dig] = cnt_r[dig] - CNT_W'(1);
        default: cnt_nxt[dig] = cnt_r[dig];
      endcase
    end
  end

  assign out_xfer = out_valid_r && !out_stall;

  always_comb begin
    fill_nxt      = fill_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    if (cmd.store) begin
      if (store_ok) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.end_set) begin
      fill_nxt    = '0;
      dropped_nxt = 1'b0;
    end
    if (cmd.em_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_mode_r   <= RD_NONE;
      acc_r       <= '0;
      for (int j = 0; j < RADIX; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      rd_mode_r   <= cmd.rd_mode;
      if (cmd.pfx) begin
        acc_r <= pfx_sum;
      end
      for (int j = 0; j < RADIX; j++) begin
        cnt_r[j] <= cnt_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= cmd.idx;
    digit_r <= cmd.digit;
    if (cmd.cap_in) begin
      v_r    <= (in_value > VALUE_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : in_value;
      last_r <= in_last;
    end
    if (cmd.conv) begin
      q_r  <= q_val;
      d0_r <= d0_val;
    end
    if (cmd.em_load) begin
      out_value_r <= bcd2bin(a_rd_r);
      out_last_r  <= cmd.em_last;
      out_ovf_r   <= dropped_r;
    end
  end

  // value store: load writes or copy-back writes, one read port
  always_ff @(posedge clk) begin
    if (cmd.store && store_ok) begin
      mem_a[fill_r[ADDR_W-1:0]] <= {d2_val, d1_val, d0_r};
    end else if (rd_mode_r == RD_CPY) begin
      mem_a[idx_r] <= b_rd_r;
    end
    if (cmd.rd_mode == RD_CNT || cmd.rd_mode == RD_SCT || cmd.rd_mode == RD_EMIT) begin
      a_rd_r <= mem_a[cmd.idx];
    end
  end

  // scratch store
  always_ff @(posedge clk) begin
    if (rd_mode_r == RD_SCT) begin
      mem_b[sct_pos] <= a_rd_r;
    end
    if (cmd.rd_mode == RD_CPY) begin
      b_rd_r <= mem_b[cmd.idx];
    end
  end

  assign status.fill     = fill_r;
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_xfer;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== design/lsdr_ctrl.sv =====
// Controller: load, per-digit count/prefix/scatter/copy passes, and emission sequencing.
`timescale 1ns / 1ps

module lsdr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cfg_wr_en,
  input  logic [lsdr_pkg::NDIG_W-1:0]  cfg_wr_data,
  input  lsdr_pkg::lsdr_status_t       status,
  output lsdr_pkg::lsdr_cmd_t          cmd
);
  import lsdr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CONV  = 10'b0000000010,
    S_STORE = 10'b0000000100,
    S_CLR   = 10'b0000001000,
    S_CNT   = 10'b0000010000,
    S_PFX   = 10'b0000100000,
    S_SCT   = 10'b0001000000,
    S_CPY   = 10'b0010000000,
    S_EMRD  = 10'b0100000000,
    S_EMLD  = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [DIG_W-1:0]  k_r, k_nxt;
  logic [NDIG_W-1:0] d_r, d_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;
  logic [CNT_W-1:0]  i_dec;
  logic [CNT_W-1:0]  n;

  assign n     = status.fill;
  assign i_dec = i_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    d_nxt       = d_r;
    ndig_nxt    = cfg_wr_en ? cfg_wr_data : ndig_r;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.rd_mode = RD_NONE;
    cmd.idx     = i_r[ADDR_W-1:0];
    cmd.digit   = d_r;
    cmd.pfx_k   = k_r;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        d_nxt     = '0;
        i_nxt     = '0;
        if (!status.last) begin
          state_nxt = S_IDLE;
        end else if (ndig_r == '0) begin
          state_nxt = S_EMRD;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_cnt = 1'b1;
        i_nxt       = '0;
        state_nxt   = S_CNT;
      end
      S_CNT: begin
        // the closing step after the last read lets the final count land
        if (i_r < n) begin
          cmd.rd_mode = RD_CNT;
          i_nxt       = i_r + CNT_W'(1);
        end else begin
          k_nxt     = '0;
          state_nxt = S_PFX;
        end
      end
      S_PFX: begin
        cmd.pfx = 1'b1;
        if (k_r == DIG_W'(RADIX - 1)) begin
          i_nxt     = n;
          state_nxt = S_SCT;
        end else begin
          k_nxt = k_r + DIG_W'(1);
        end
      end
      S_SCT: begin
        // walk backward so equal digits keep their order
        if (i_r != '0) begin
          cmd.rd_mode = RD_SCT;
          cmd.idx     = i_dec[ADDR_W-1:0];
          i_nxt       = i_dec;
        end else begin
          state_nxt = S_CPY;
        end
      end
      S_CPY: begin
        if (i_r < n) begin
          cmd.rd_mode = RD_CPY;
          i_nxt       = i_r + CNT_W'(1);
        end else if ((NDIG_W + 1)'(d_r) + (NDIG_W + 1)'(1) == (NDIG_W + 1)'(ndig_r)) begin
          i_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          d_nxt     = d_r + NDIG_W'(1);
          state_nxt = S_CLR;
        end
      end
      S_EMRD: begin
        cmd.rd_mode = RD_EMIT;
        state_nxt   = S_EMLD;
      end
      S_EMLD: begin
        if (status.out_free) begin
          cmd.em_load = 1'b1;
          cmd.em_last = ((i_r + CNT_W'(1)) == n);
          if (cmd.em_last) begin
            cmd.end_set = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      d_r     <= '0;
      ndig_r  <= NDIG_W'(3);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
      ndig_r  <= ndig_nxt;
    end
  end

endmodule

// ===== design/lsd_radix_sort_base10_unit.sv =====
// Top level of the base-10 LSD radix sorter: controller plus datapath.
//
// Input channel (in_valid/in_stall, in_value, in_last): one value per transfer.
// Values above 999 are clamped to 999. Each transfer passes through capture and
// two divide-by-ten steps into BCD, and in_stall stays high through both steps.
// A transfer with in_last set closes the set and starts the sort. The store
// holds 64 values; extras are dropped and out_overflow is set on the set.
// Sort: num_digits passes (cfg_wr_en/cfg_wr_data, reset 3) over the n stored
// values, each made of a count walk, 10-step prefix sum, backward scatter and
// copy-back, each walk bound by the single store read port.
// Output channel (out_valid/out_stall): n transfers in ascending order of the
// low num_digits decimal digits, out_last_out on the final one. After the last
// pass each result is read from the store, then loaded into the output register
// once that register is free or being taken. A stall holds the output register
// and pauses the emission walk. Once the final result is loaded the block takes
// new input at once. Synchronous reset clears the set, the counters and out_valid
// and restores num_digits to 3. Write cfg only while the block is idle.
`timescale 1ns / 1ps

module lsd_radix_sort_base10_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsdr_pkg::VALUE_W-1:0]  in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsdr_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                          out_last_out,
  output logic                          out_overflow,
  input  logic                          cfg_wr_en,
  input  logic [lsdr_pkg::NDIG_W-1:0]   cfg_wr_data
);
  import lsdr_pkg::*;

  lsdr_cmd_t    cmd;
  lsdr_status_t status;

  lsdr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .cmd         (cmd)
  );

  lsdr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule

// ===== sim/sort_order_checker.sv =====
// Checker for the base-10 radix sorter: predicts each sorted set and compares the output stream.
`timescale 1ns / 1ps

module sort_order_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [lsdr_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [lsdr_pkg::VALUE_W-1:0] out_sorted_value,
  input  logic                         out_last_out,
  input  logic                         out_overflow,
  input  logic                         cfg_wr_en,
  input  logic [lsdr_pkg::NDIG_W-1:0]  cfg_wr_data,
  output int                           fail_count,
  output int                           pending
);
  import lsdr_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } sorted_word_t;

  sorted_word_t       sorted_words_q[$];
  logic [VALUE_W-1:0] loaded_vals[MAX_ITEMS];
  int                 loaded_cnt;
  logic               dropped;
  logic [NDIG_W-1:0]  pass_cnt;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  // Sort key after the given number of LSD passes: the low decimal digits only
  function automatic int digit_key(input logic [VALUE_W-1:0] v, input logic [NDIG_W-1:0] nd);
    case (nd)
      2'd0:    return 0;
      2'd1:    return int'(v) % RADIX;
      2'd2:    return int'(v) % (RADIX * RADIX);
      default: return int'(v);
    endcase
  endfunction

  // Stable insertion sort on the key gives the same order as the digit passes
  task automatic sort_and_queue_set();
    logic [VALUE_W-1:0] order[MAX_ITEMS];
    logic [VALUE_W-1:0] t;
    sorted_word_t       w;
    int                 i;
    int                 j;
    for (i = 0; i < loaded_cnt; i++) order[i] = loaded_vals[i];
    for (i = 1; i < loaded_cnt; i++) begin
      t = order[i];
      j = i - 1;
      while (j >= 0 && digit_key(order[j], pass_cnt) > digit_key(t, pass_cnt)) begin
        order[j + 1] = order[j];
        j--;
      end
      order[j + 1] = t;
    end
    for (i = 0; i < loaded_cnt; i++) begin
      w.value = order[i];
      w.last  = (i == loaded_cnt - 1);
      w.ovf   = dropped;
      sorted_words_q.push_back(w);
    end
    loaded_cnt = 0;
    dropped    = 1'b0;
  endtask

  always @(posedge clk) begin
    logic [VALUE_W-1:0] v;
    sorted_word_t       w;
    if (!rst_n) begin
      loaded_cnt = 0;
      dropped    = 1'b0;
      pass_cnt   = 2'd3;
      sorted_words_q.delete();
    end else begin
      if (cfg_wr_en) pass_cnt = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (sorted_words_q.size() == 0) begin
          report("unexpected result value", -1, out_sorted_value);
        end else begin
          w = sorted_words_q.pop_front();
          if (out_sorted_value !== w.value) report("sorted_value", w.value, out_sorted_value);
          if (out_last_out !== w.last) report("last_out", w.last, out_last_out);
          if (out_overflow !== w.ovf) report("overflow", w.ovf, out_overflow);
        end
      end
      if (in_valid && !in_stall) begin
        v = (in_value > VALUE_MAX) ? VALUE_W'(VALUE_MAX) : in_value;
        if (loaded_cnt < MAX_ITEMS) begin
          loaded_vals[loaded_cnt] = v;
          loaded_cnt++;
        end else begin
          dropped = 1'b1;
        end
        if (in_last) sort_and_queue_set();
      end
    end
    pending = sorted_words_q.size();
  end

endmodule

// ===== sim/lsd_radix_sort_base10_unit_tb.sv =====
// Testbench top for the base-10 radix sorter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module lsd_radix_sort_base10_unit_tb;
  import lsdr_pkg::*;

  localparam int ITEM_TARGET = 280;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_CYC  = 8;

  typedef enum int {NO_STALL, LIGHT_STALL, HEAVY_STALL} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] out_sorted_value;
  logic               out_last_out;
  logic               out_overflow;
  logic               cfg_wr_en = 1'b0;
  logic [NDIG_W-1:0]  cfg_wr_data = '0;

  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 items_sent = 0;
  stall_mode_t        stall_mode = NO_STALL;
  int                 seg_left = 0;

  lsd_radix_sort_base10_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  sort_order_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: segments of random length, each with its own stall density
  always @(posedge clk) begin
    if (seg_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      seg_left   <= $urandom_range(10, 150);
    end else begin
      seg_left <= seg_left - 1;
    end
    case (stall_mode)
      NO_STALL:    out_stall <= 1'b0;
      LIGHT_STALL: out_stall <= ($urandom_range(0, 2) == 0);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** lsd_radix_sort_base10_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap between bursts; called right after a rising edge
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send(input logic [VALUE_W-1:0] v, input logic l);
    pace();
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait for every predicted result, then let the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_passes(input logic [NDIG_W-1:0] nd);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= nd;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return VALUE_W'($urandom_range(VALUE_MAX + 1, 1023));
    if (r < 4) return VALUE_W'($urandom_range(0, 30));   // many repeats of low digits
    return VALUE_W'($urandom_range(0, VALUE_MAX));
  endfunction

  task automatic send_random_set(input int n);
    int k;
    for (k = 0; k < n; k++) send(rand_value(), k == n - 1);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pass count of 3: extremes and saturation
    send(10'd0, 1'b0);
    send(10'd999, 1'b0);
    send(10'd1023, 1'b0);
    send(10'd512, 1'b0);
    send(10'd5, 1'b0);
    send(10'd500, 1'b0);
    send(10'd50, 1'b0);
    send(10'd1, 1'b1);
    // one-value set
    send(10'd7, 1'b1);
    // no passes: arrival order
    write_passes(2'd0);
    send(10'd30, 1'b0);
    send(10'd10, 1'b0);
    send(10'd20, 1'b1);
    // one pass: ties on the low digit keep arrival order
    write_passes(2'd1);
    send(10'd15, 1'b0);
    send(10'd25, 1'b0);
    send(10'd11, 1'b0);
    send(10'd900, 1'b0);
    send(10'd21, 1'b1);
    write_passes(2'd2);
    send(10'd123, 1'b0);
    send(10'd23, 1'b0);
    send(10'd923, 1'b0);
    send(10'd1000, 1'b0);
    send(10'd3, 1'b1);

    // store overflow, final mark among the dropped values
    write_passes(2'd3);
    send_random_set(MAX_ITEMS + 2);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) write_passes(NDIG_W'($urandom_range(0, 3)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
                                      : $urandom_range(1, 12);
      send_random_set(n);
    end

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** lsd_radix_sort_base10_unit: PASSED **");
    end else begin
      $display("** lsd_radix_sort_base10_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lsdr_pkg.sv
design/lsdr_dp.sv
design/lsdr_ctrl.sv
design/lsd_radix_sort_base10_unit.sv
sim/sort_order_checker.sv
sim/lsd_radix_sort_base10_unit_tb.sv
